/* sv/fcdma_pkg.sv */
`timescale 1ns / 1ps
// Shared types and constants for the four-channel DMA controller.
// No dependencies; every other file of the block imports this package.
package fcdma_pkg;

	localparam logic [2:0] OP_REG_WR  = 3'd0;
	localparam logic [2:0] OP_REG_RD  = 3'd1;
	localparam logic [2:0] OP_PAGE_WR = 3'd2;
	localparam logic [2:0] OP_PAGE_RD = 3'd3;
	localparam logic [2:0] OP_SERVICE = 3'd4;

	localparam logic [3:0] REG_STATUS     = 4'h8;
	localparam logic [3:0] REG_REQUEST    = 4'h9;
	localparam logic [3:0] REG_MASK       = 4'hA;
	localparam logic [3:0] REG_MODE       = 4'hB;
	localparam logic [3:0] REG_CLEAR_FF   = 4'hC;
	localparam logic [3:0] REG_MULTI_MASK = 4'hF;

	localparam logic [1:0] TYPE_WRITE   = 2'd1;
	localparam logic [1:0] MODE_CASCADE = 2'd3;

	localparam int FLAG_BITS = 4;

	typedef struct packed {
		logic [2:0] op;
		logic [3:0] reg_index;
		logic [7:0] write_data;
		logic [1:0] channel;
	} item_t;

	typedef struct packed {
		logic [7:0]  read_data;
		logic        xfer_valid;
		logic [23:0] mem_address;
		logic        to_memory;
		logic        terminal_count;
	} result_t;

	typedef struct packed {
		logic valid;
		logic fire;
	} stage_ctl_t;

endpackage

/* sv/fcdma_in_stage.sv */
`timescale 1ns / 1ps
// Input register stage: unpacks an accepted stream word into an item.
// Depends on fcdma_pkg.
module fcdma_in_stage (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                s_tvalid,
	output logic                s_tready,
	input  logic [15:0]         s_tdata,
	input  logic [2:0]          s_tuser,
	input  logic                out_free,
	output fcdma_pkg::item_t    item_s1,
	output fcdma_pkg::stage_ctl_t ctl
);
	import fcdma_pkg::*;

	logic valid_s1;

	assign s_tready = !valid_s1 || out_free;
	assign ctl      = '{valid: valid_s1, fire: valid_s1 && out_free};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_tready) begin
			valid_s1 <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_tready && s_tvalid) begin
			item_s1.op         <= s_tuser;
			item_s1.reg_index  <= s_tdata[3:0];
			item_s1.write_data <= s_tdata[11:4];
			item_s1.channel    <= s_tdata[13:12];
		end
	end

endmodule

/* sv/fcdma_core.sv */
`timescale 1ns / 1ps
// Channel register file and the single-pass decode of one bus event.
// Depends on fcdma_pkg.
module fcdma_core #(
	parameter int CHANNELS = 4
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  fcdma_pkg::item_t     item_s1,
	input  logic                 fire,
	input  logic                 cfg_we,
	input  logic                 cfg_wdata,
	output fcdma_pkg::result_t   result
);
	import fcdma_pkg::*;

	localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
	localparam logic [3:0] CH_LIMIT = 4'(CHANNELS);

	logic [15:0] base_addr_q [CHANNELS];
	logic [15:0] cur_addr_q  [CHANNELS];
	logic [15:0] base_cnt_q  [CHANNELS];
	logic [15:0] cur_cnt_q   [CHANNELS];
	logic [5:0]  mode_q      [CHANNELS];
	logic [7:0]  page_q      [CHANNELS];
	logic [CHANNELS-1:0] mask_q, tc_q, req_q;
	logic ff_q, word_wide_q;

	logic [CHANNELS-1:0] mask_d, tc_d, req_d;
	logic ff_d;
	logic [3:0] sel_ext, dc_ext;
	logic [CH_W-1:0] sel, dc;
	logic sel_ok, dc_ok, is_port;
	logic [15:0] a_cur, c_cur, a_base, c_base;
	logic [5:0] m_cur;
	logic [7:0] p_cur, tc_pad, req_pad;
	logic base_addr_we, cur_addr_we, base_cnt_we, cur_cnt_we, page_we, mode_we;
	logic [15:0] base_addr_wd, cur_addr_wd, base_cnt_wd, cur_cnt_wd;

	assign is_port = (item_s1.reg_index < REG_STATUS);
	assign sel_ext = (item_s1.op == OP_PAGE_WR || item_s1.op == OP_PAGE_RD ||
		item_s1.op == OP_SERVICE) ? {2'b00, item_s1.channel} :
		{2'b00, item_s1.reg_index[2:1]};
	assign dc_ext  = {2'b00, item_s1.write_data[1:0]};
	assign sel     = sel_ext[CH_W-1:0];
	assign dc      = dc_ext[CH_W-1:0];
	assign sel_ok  = (sel_ext < CH_LIMIT);
	assign dc_ok   = (dc_ext < CH_LIMIT);

	assign a_cur   = cur_addr_q[sel];
	assign c_cur   = cur_cnt_q[sel];
	assign a_base  = base_addr_q[sel];
	assign c_base  = base_cnt_q[sel];
	assign m_cur   = mode_q[sel];
	assign p_cur   = page_q[sel];
	assign tc_pad  = 8'(tc_q);
	assign req_pad = 8'(req_q);

	always_comb begin
		result       = '0;
		mask_d       = mask_q;
		tc_d         = tc_q;
		req_d        = req_q;
		ff_d         = ff_q;
		base_addr_we = 1'b0;
		cur_addr_we  = 1'b0;
		base_cnt_we  = 1'b0;
		cur_cnt_we   = 1'b0;
		page_we      = 1'b0;
		mode_we      = 1'b0;
		base_addr_wd = ff_q ? {item_s1.write_data, a_base[7:0]} :
			{a_base[15:8], item_s1.write_data};
		cur_addr_wd  = ff_q ? {item_s1.write_data, a_cur[7:0]} :
			{a_cur[15:8], item_s1.write_data};
		base_cnt_wd  = ff_q ? {item_s1.write_data, c_base[7:0]} :
			{c_base[15:8], item_s1.write_data};
		cur_cnt_wd   = ff_q ? {item_s1.write_data, c_cur[7:0]} :
			{c_cur[15:8], item_s1.write_data};
		case (item_s1.op)
			OP_REG_WR, OP_REG_RD: begin
				if (is_port) begin
					if (sel_ok) begin
						if (item_s1.op == OP_REG_WR) begin
							if (item_s1.reg_index[0]) begin
								base_cnt_we = 1'b1;
								cur_cnt_we  = 1'b1;
							end else begin
								base_addr_we = 1'b1;
								cur_addr_we  = 1'b1;
							end
						end else begin
							if (item_s1.reg_index[0]) begin
								result.read_data = ff_q ? c_cur[15:8] : c_cur[7:0];
							end else begin
								result.read_data = ff_q ? a_cur[15:8] : a_cur[7:0];
							end
						end
					end
					ff_d = ~ff_q;
				end else if (item_s1.op == OP_REG_RD) begin
					if (item_s1.reg_index == REG_STATUS) begin
						result.read_data = {req_pad[FLAG_BITS-1:0], tc_pad[FLAG_BITS-1:0]};
						tc_d = '0;
					end
				end else begin
					case (item_s1.reg_index)
						REG_REQUEST: begin
							if (dc_ok) begin
								req_d[dc] = item_s1.write_data[2];
							end
						end
						REG_MASK: begin
							if (dc_ok) begin
								mask_d[dc] = item_s1.write_data[2];
							end
						end
						REG_MODE: begin
							mode_we = dc_ok;
						end
						REG_CLEAR_FF: begin
							ff_d = 1'b0;
						end
						REG_MULTI_MASK: begin
							for (int i = 0; i < CHANNELS; i++) begin
								mask_d[i] = (i < FLAG_BITS) ? item_s1.write_data[i] : 1'b0;
							end
						end
						default: begin
						end
					endcase
				end
			end
			OP_PAGE_WR: begin
				page_we = sel_ok;
			end
			OP_PAGE_RD: begin
				if (sel_ok) begin
					result.read_data = p_cur;
				end
			end
			OP_SERVICE: begin
				if (sel_ok && !mask_q[sel] && m_cur[5:4] != MODE_CASCADE) begin
					result.xfer_valid  = 1'b1;
					result.to_memory   = (m_cur[1:0] == TYPE_WRITE);
					result.mem_address = word_wide_q ? {p_cur[7:1], a_cur, 1'b0} :
						{p_cur, a_cur};
					cur_addr_we = 1'b1;
					cur_cnt_we  = 1'b1;
					cur_addr_wd = m_cur[3] ? a_cur - 16'd1 : a_cur + 16'd1;
					cur_cnt_wd  = c_cur - 16'd1;
					if (c_cur == 16'd0) begin
						result.terminal_count = 1'b1;
						tc_d[sel]  = 1'b1;
						req_d[sel] = 1'b0;
						if (m_cur[2]) begin
							cur_addr_wd = a_base;
							cur_cnt_wd  = c_base;
						end else begin
							cur_cnt_wd  = 16'hFFFF;
							mask_d[sel] = 1'b1;
						end
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < CHANNELS; i++) begin
				base_addr_q[i] <= '0;
				cur_addr_q[i]  <= '0;
				base_cnt_q[i]  <= '0;
				cur_cnt_q[i]   <= '0;
				mode_q[i]      <= '0;
				page_q[i]      <= '0;
			end
			mask_q      <= '1;
			tc_q        <= '0;
			req_q       <= '0;
			ff_q        <= 1'b0;
			word_wide_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				word_wide_q <= cfg_wdata;
			end
			if (fire) begin
				mask_q <= mask_d;
				tc_q   <= tc_d;
				req_q  <= req_d;
				ff_q   <= ff_d;
				if (base_addr_we) begin
					base_addr_q[sel] <= base_addr_wd;
				end
				if (cur_addr_we) begin
					cur_addr_q[sel] <= cur_addr_wd;
				end
				if (base_cnt_we) begin
					base_cnt_q[sel] <= base_cnt_wd;
				end
				if (cur_cnt_we) begin
					cur_cnt_q[sel] <= cur_cnt_wd;
				end
				if (page_we) begin
					page_q[sel] <= item_s1.write_data;
				end
				if (mode_we) begin
					mode_q[dc] <= item_s1.write_data[7:2];
				end
			end
		end
	end

endmodule

/* sv/fcdma_out_stage.sv */
`timescale 1ns / 1ps
// Result register stage: holds one result word until the sink takes it.
// Depends on fcdma_pkg.
module fcdma_out_stage (
	input  logic                  clk,
	input  logic                  arst_n,
	input  fcdma_pkg::stage_ctl_t ctl,
	input  fcdma_pkg::result_t    result,
	output logic                  out_free,
	output logic                  m_tvalid,
	input  logic                  m_tready,
	output logic [39:0]           m_tdata,
	output logic [0:0]            m_tuser
);
	import fcdma_pkg::*;

	result_t result_q;

	assign out_free = !m_tvalid || m_tready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (ctl.fire) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.fire) begin
			result_q <= result;
		end
	end

	assign m_tdata = {6'b0, result_q.terminal_count, result_q.to_memory,
		result_q.mem_address, result_q.read_data};
	assign m_tuser = result_q.xfer_valid;

endmodule

/* sv/four_channel_dma_controller.sv */
`timescale 1ns / 1ps
// Top level of the four-channel DMA controller; instantiates fcdma_in_stage,
// fcdma_core and fcdma_out_stage and uses fcdma_pkg.
//
// Each input word is one bus event: a controller port write or read, a page
// register write or read, or a single-transfer service on one channel. Every
// word yields exactly one result word, which passes through the input register
// and is presented from the result register, and a new word is accepted every
// cycle while the result side keeps up; the rate is set by the read-modify-write
// of the channel register file between the input register and the result
// register. A stalled result stalls the input only once both registers are full.
// The word_wide register may be written only while no word is in flight.
module four_channel_dma_controller #(
	parameter int CHANNELS = 4
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// s_tdata: reg_index[3:0], write_data[11:4], channel[13:12], zero [15:14].
	input  logic [15:0] s_tdata,
	// s_tuser: op[2:0].
	input  logic [2:0]  s_tuser,
	output logic        m_tvalid,
	input  logic        m_tready,
	// m_tdata: read_data[7:0], mem_address[31:8], to_memory[32],
	// terminal_count[33], zero [39:34].
	output logic [39:0] m_tdata,
	// m_tuser: xfer_valid[0].
	output logic [0:0]  m_tuser,
	input  logic        cfg_we,
	input  logic        cfg_wdata
);
	import fcdma_pkg::*;

	item_t      item_s1;
	result_t    result;
	stage_ctl_t ctl;
	logic       out_free;

	fcdma_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.s_tdata  (s_tdata),
		.s_tuser  (s_tuser),
		.out_free (out_free),
		.item_s1  (item_s1),
		.ctl      (ctl)
	);

	fcdma_core #(
		.CHANNELS (CHANNELS)
	) u_core (
		.clk       (clk),
		.arst_n    (arst_n),
		.item_s1   (item_s1),
		.fire      (ctl.fire),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.result    (result)
	);

	fcdma_out_stage u_out (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.result   (result),
		.out_free (out_free),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.m_tdata  (m_tdata),
		.m_tuser  (m_tuser)
	);

	// A pending item that cannot move on must keep its contents.
	a_hold_s1: assert property (@(posedge clk) disable iff (!arst_n)
		ctl.valid && !out_free |=> ctl.valid && $stable(item_s1))
		else $error("input stage item changed while stalled");

	// The input side stalls only when both stages are full and the sink waits.
	a_stall_full: assert property (@(posedge clk) disable iff (!arst_n)
		!s_tready |-> ctl.valid && m_tvalid && !m_tready)
		else $error("input stalled with room in the pipeline");

	// Terminal count is only reported on a performed transfer.
	a_tc_xfer: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tdata[33] |-> m_tuser[0])
		else $error("terminal count without a transfer");

	// A transfer result never carries read data.
	a_xfer_rd: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && m_tuser[0] |-> m_tdata[7:0] == 8'd0)
		else $error("transfer result with nonzero read data");

endmodule

/* verif/four_channel_dma_controller_tb.sv */
`timescale 1ns / 1ps
// Self-checking testbench for four_channel_dma_controller: a predictor tracks every
// channel register and the result stream is checked word by word. Needs fcdma_pkg.
module four_channel_dma_controller_tb;
	import fcdma_pkg::*;

	localparam int          WATCHDOG_LIMIT   = 2000;
	localparam int          HOLD_CYCLES      = 120;
	localparam int          MB_AUTOINIT      = 2;
	localparam int          MB_DECREMENT     = 3;
	localparam int          SEL_FLAG_BIT     = 2;
	localparam logic [3:0]  REG_MASTER_CLEAR = 4'hD;
	localparam logic [3:0]  REG_CLEAR_MASK   = 4'hE;
	localparam logic [2:0]  OP_UNUSED_LO     = 3'd5;
	localparam logic [2:0]  OP_UNUSED_HI     = 3'd7;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        s_tvalid = 1'b0;
	logic        s_tready;
	logic [15:0] s_tdata = '0;
	logic [2:0]  s_tuser = '0;
	logic        m_tvalid;
	logic        m_tready = 1'b0;
	logic [39:0] m_tdata;
	logic [0:0]  m_tuser;
	logic        cfg_we = 1'b0;
	logic        cfg_wdata = 1'b0;

	four_channel_dma_controller dut (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.s_tuser(s_tuser),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.m_tuser(m_tuser),
		.cfg_we(cfg_we),
		.cfg_wdata(cfg_wdata)
	);

	logic [15:0] base_addr[4];
	logic [15:0] cur_addr[4];
	logic [15:0] base_cnt[4];
	logic [15:0] cur_cnt[4];
	logic [5:0]  mode_r[4];
	logic [7:0]  page_r[4];
	logic [3:0]  mask_r;
	logic [3:0]  tc_r;
	logic [3:0]  req_r;
	logic        ff_r;
	logic        word_wide_r;

	result_t expected_results[$];
	int      mismatches = 0;
	int      words_sent = 0;
	int      transfers_seen = 0;
	int      terminal_counts_seen = 0;
	int      burst_left = 0;
	bit      no_gaps = 0;
	bit      hold_request = 0;
	bit      hold_active = 0;
	int      idle_cycles = 0;

	initial begin
		forever #5 clk = ~clk;
	end

	function automatic void reset_channels();
		for (int i = 0; i < 4; i++) begin
			base_addr[i] = '0;
			cur_addr[i] = '0;
			base_cnt[i] = '0;
			cur_cnt[i] = '0;
			mode_r[i] = '0;
			page_r[i] = '0;
		end
		mask_r = 4'hF;
		tc_r = '0;
		req_r = '0;
		ff_r = 1'b0;
		word_wide_r = 1'b0;
	endfunction

	function automatic result_t predict_result(input logic [2:0] op, input logic [3:0] rg,
			input logic [7:0] d, input logic [1:0] ch);
		result_t r;
		logic [1:0] c;
		logic [5:0] m;
		logic [15:0] a;
		r = '0;
		if (op == OP_REG_WR || op == OP_REG_RD) begin
			if (rg < 4'd8) begin
				c = rg[2:1];
				if (op == OP_REG_WR) begin
					if (rg[0]) begin
						if (ff_r) begin
							base_cnt[c][15:8] = d;
							cur_cnt[c][15:8] = d;
						end else begin
							base_cnt[c][7:0] = d;
							cur_cnt[c][7:0] = d;
						end
					end else begin
						if (ff_r) begin
							base_addr[c][15:8] = d;
							cur_addr[c][15:8] = d;
						end else begin
							base_addr[c][7:0] = d;
							cur_addr[c][7:0] = d;
						end
					end
				end else begin
					a = rg[0] ? cur_cnt[c] : cur_addr[c];
					r.read_data = ff_r ? a[15:8] : a[7:0];
				end
				ff_r = ~ff_r;
			end else if (op == OP_REG_RD) begin
				if (rg == REG_STATUS) begin
					r.read_data = {req_r, tc_r};
					tc_r = '0;
				end
			end else begin
				c = d[1:0];
				case (rg)
					REG_REQUEST: req_r[c] = d[SEL_FLAG_BIT];
					REG_MASK: mask_r[c] = d[SEL_FLAG_BIT];
					REG_MODE: mode_r[c] = d[7:2];
					REG_CLEAR_FF: ff_r = 1'b0;
					REG_MULTI_MASK: mask_r = d[3:0];
					default: ;
				endcase
			end
		end else if (op == OP_PAGE_WR) begin
			page_r[ch] = d;
		end else if (op == OP_PAGE_RD) begin
			r.read_data = page_r[ch];
		end else if (op == OP_SERVICE) begin
			if (!mask_r[ch] && mode_r[ch][5:4] != MODE_CASCADE) begin
				m = mode_r[ch];
				a = cur_addr[ch];
				r.xfer_valid = 1'b1;
				r.to_memory = (m[1:0] == TYPE_WRITE);
				r.mem_address = word_wide_r ? {page_r[ch][7:1], a, 1'b0} : {page_r[ch], a};
				cur_addr[ch] = m[MB_DECREMENT] ? a - 16'd1 : a + 16'd1;
				if (cur_cnt[ch] == 16'd0) begin
					r.terminal_count = 1'b1;
					tc_r[ch] = 1'b1;
					req_r[ch] = 1'b0;
					if (m[MB_AUTOINIT]) begin
						cur_addr[ch] = base_addr[ch];
						cur_cnt[ch] = base_cnt[ch];
					end else begin
						cur_cnt[ch] = 16'hFFFF;
						mask_r[ch] = 1'b1;
					end
				end else begin
					cur_cnt[ch] = cur_cnt[ch] - 16'd1;
				end
			end
		end
		return r;
	endfunction

	task automatic send_word(input logic [2:0] op, input logic [3:0] rg, input logic [7:0] d,
			input logic [1:0] ch);
		int gap;
		if (burst_left == 0 && !no_gaps) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
			repeat (gap) begin
				@(negedge clk);
				s_tvalid <= 1'b0;
			end
			burst_left = $urandom_range(1, 24);
		end
		if (burst_left > 0)
			burst_left--;
		@(negedge clk);
		s_tvalid <= 1'b1;
		s_tuser <= op;
		s_tdata <= {2'b00, ch, d, rg};
		do @(posedge clk); while (!s_tready);
		expected_results.push_back(predict_result(op, rg, d, ch));
		words_sent++;
	endtask

	task automatic load_channel(input logic [1:0] ch, input logic [15:0] addr,
			input logic [15:0] cnt, input logic [7:0] mode_byte, input logic [7:0] pg);
		send_word(OP_REG_WR, REG_CLEAR_FF, 8'($urandom_range(0, 255)), ch);
		send_word(OP_REG_WR, {1'b0, ch, 1'b0}, addr[7:0], ch);
		send_word(OP_REG_WR, {1'b0, ch, 1'b0}, addr[15:8], ch);
		send_word(OP_REG_WR, {1'b0, ch, 1'b1}, cnt[7:0], ch);
		send_word(OP_REG_WR, {1'b0, ch, 1'b1}, cnt[15:8], ch);
		send_word(OP_REG_WR, REG_MODE, {mode_byte[7:2], ch}, ch);
		send_word(OP_PAGE_WR, REG_STATUS, pg, ch);
		send_word(OP_REG_WR, REG_MASK, {6'b0, ch}, ch);
	endtask

	task automatic set_word_wide(input logic v);
		@(negedge clk);
		s_tvalid <= 1'b0;
		while (expected_results.size() != 0)
			@(negedge clk);
		repeat (4) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		word_wide_r = v;
	endtask

	// Reset values, masked service, autoinit reload, decrement wrap, cascade and odd ports.
	task automatic test_directed();
		send_word(OP_REG_RD, REG_STATUS, 8'h00, 2'd0);
		send_word(OP_SERVICE, REG_STATUS, 8'h00, 2'd0);
		load_channel(2'd0, 16'hFFFF, 16'd1, 8'b01_0_1_01_00, 8'hFF);
		repeat (3) send_word(OP_SERVICE, REG_STATUS, 8'h00, 2'd0);
		send_word(OP_REG_RD, REG_STATUS, 8'h00, 2'd0);
		load_channel(2'd1, 16'h0000, 16'd0, 8'b00_1_0_00_00, 8'h80);
		repeat (2) send_word(OP_SERVICE, REG_STATUS, 8'h00, 2'd1);
		send_word(OP_REG_WR, REG_MULTI_MASK, 8'hF0, 2'd0);
		send_word(OP_REG_WR, REG_MODE, 8'hC2, 2'd0);
		send_word(OP_SERVICE, REG_STATUS, 8'h00, 2'd2);
		send_word(OP_REG_WR, REG_REQUEST, 8'h07, 2'd0);
		send_word(OP_REG_RD, REG_STATUS, 8'h00, 2'd0);
		send_word(OP_REG_RD, REG_MODE, 8'h00, 2'd0);
		send_word(OP_REG_WR, REG_MASTER_CLEAR, 8'hFF, 2'd3);
		send_word(OP_REG_WR, REG_CLEAR_MASK, 8'hFF, 2'd3);
		send_word(OP_UNUSED_HI, 4'hF, 8'hFF, 2'd3);
		send_word(OP_UNUSED_LO, REG_STATUS, 8'h55, 2'd1);
	endtask

	// Mostly well-formed channel programming followed by services, with reads and noise.
	task automatic test_random_mix(input int count);
		int sent;
		int pick;
		logic [15:0] cnt;
		sent = 0;
		while (sent < count) begin
			pick = $urandom_range(0, 99);
			if (pick < 10) begin
				cnt = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
				load_channel(2'($urandom_range(0, 3)), 16'($urandom), cnt,
					8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
				sent += 8;
			end else if (pick < 65) begin
				send_word(OP_SERVICE, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
				sent++;
			end else if (pick < 80) begin
				send_word(OP_REG_RD, 4'($urandom_range(0, 15)), 8'($urandom_range(0, 255)),
					2'($urandom_range(0, 3)));
				sent++;
			end else begin
				send_word(3'($urandom_range(0, 7)), 4'($urandom_range(0, 15)),
					8'($urandom_range(0, 255)), 2'($urandom_range(0, 3)));
				sent++;
			end
		end
	endtask

	task automatic test_word_wide_phases();
		logic settings[5] = '{1'b1, 1'b0, 1'b1, 1'b1, 1'b0};
		for (int p = 0; p < 5; p++) begin
			set_word_wide(settings[p]);
			test_random_mix(210);
		end
	endtask

	// The result side holds off while words keep coming, so the input must stall.
	task automatic test_backpressure();
		@(negedge clk);
		s_tvalid <= 1'b0;
		hold_request = 1;
		wait (hold_active);
		no_gaps = 1;
		test_random_mix(40);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (!hold_active);
		no_gaps = 0;
	endtask

	initial begin : result_side
		int span;
		int style;
		forever begin
			if (hold_request) begin
				hold_active = 1;
				repeat (HOLD_CYCLES) begin
					@(negedge clk);
					m_tready <= 1'b0;
				end
				hold_request = 0;
				hold_active = 0;
			end else begin
				style = $urandom_range(0, 3);
				span = $urandom_range(4, 40);
				repeat (span) begin
					@(negedge clk);
					case (style)
						0: m_tready <= 1'b1;
						1: m_tready <= 1'($urandom_range(0, 1));
						2: m_tready <= ($urandom_range(0, 3) == 0);
						default: m_tready <= ~m_tready;
					endcase
				end
			end
		end
	end

	always @(posedge clk) begin : check_results
		result_t want;
		result_t got;
		if (arst_n && m_tvalid && m_tready) begin
			got.read_data = m_tdata[7:0];
			got.mem_address = m_tdata[31:8];
			got.to_memory = m_tdata[32];
			got.terminal_count = m_tdata[33];
			got.xfer_valid = m_tuser[0];
			if (got.xfer_valid === 1'b1)
				transfers_seen++;
			if (got.terminal_count === 1'b1)
				terminal_counts_seen++;
			if (expected_results.size() == 0) begin
				mismatches++;
				if (mismatches <= 10)
					$display("%0t: unexpected result word rd=%h xv=%b addr=%h tm=%b tc=%b",
						$realtime, got.read_data, got.xfer_valid, got.mem_address,
						got.to_memory, got.terminal_count);
			end else begin
				want = expected_results.pop_front();
				if (got.read_data !== want.read_data || got.xfer_valid !== want.xfer_valid ||
						got.mem_address !== want.mem_address ||
						got.to_memory !== want.to_memory ||
						got.terminal_count !== want.terminal_count) begin
					mismatches++;
					if (mismatches <= 10)
						$display("%0t: expected rd=%h xv=%b addr=%h tm=%b tc=%b, got rd=%h xv=%b addr=%h tm=%b tc=%b",
							$realtime, want.read_data, want.xfer_valid, want.mem_address,
							want.to_memory, want.terminal_count, got.read_data,
							got.xfer_valid, got.mem_address, got.to_memory,
							got.terminal_count);
				end
			end
		end
	end

	always @(posedge clk) begin
		if (!arst_n || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("Timeout: no word moved for %0d cycles", WATCHDOG_LIMIT);
			$display("Some tests failed");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	initial begin
		reset_channels();
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		test_directed();
		test_word_wide_phases();
		test_backpressure();
		set_word_wide(1'b0);
		test_random_mix(40);
		@(negedge clk);
		s_tvalid <= 1'b0;
		wait (expected_results.size() == 0);
		repeat (8) @(posedge clk);
		$display("Ran %0d words through both address widths, with %0d transfers and %0d terminal counts.",
			words_sent, transfers_seen, terminal_counts_seen);
		$display("Result words left unchecked: %0d, mismatches: %0d.",
			expected_results.size(), mismatches);
		if (mismatches == 0 && expected_results.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

endmodule

/* files.f */
sv/fcdma_pkg.sv
sv/fcdma_in_stage.sv
sv/fcdma_core.sv
sv/fcdma_out_stage.sv
sv/four_channel_dma_controller.sv
verif/four_channel_dma_controller_tb.sv
